FILE: sv/hrft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrft_pkg
// shared types and constants of the humidity rise fan trigger
// ----------------------------------------------------------------------------
package hrft_pkg;

  // payload of one poll
  typedef struct packed {
    logic [31:0] now_seconds;
    logic        sensor_ok;
    logic [6:0]  humidity;
  } in_item_t;

  // payload of one result
  typedef struct packed {
    logic        fan_on;
    logic        sample_taken;
    logic [14:0] short_average;
    logic [14:0] long_average;
  } out_item_t;

  // configuration register file contents
  typedef struct packed {
    logic [15:0] sample_period;
    logic [6:0]  short_window;
    logic [6:0]  long_window;
    logic [31:0] max_on_seconds;
    logic [6:0]  trigger_cap;
  } cfg_t;

  // register indexes
  localparam logic [2:0] REG_SAMPLE_PERIOD  = 3'd0;
  localparam logic [2:0] REG_SHORT_WINDOW   = 3'd1;
  localparam logic [2:0] REG_LONG_WINDOW    = 3'd2;
  localparam logic [2:0] REG_MAX_ON_SECONDS = 3'd3;
  localparam logic [2:0] REG_TRIGGER_CAP    = 3'd4;

  // register reset values
  localparam logic [15:0] RST_SAMPLE_PERIOD  = 16'd60;
  localparam logic [6:0]  RST_SHORT_WINDOW   = 7'd4;
  localparam logic [6:0]  RST_LONG_WINDOW    = 7'd64;
  localparam logic [31:0] RST_MAX_ON_SECONDS = 32'd14400;
  localparam logic [6:0]  RST_TRIGGER_CAP    = 7'd85;

  // datapath widths
  localparam int SH_W   = 26;  // dividend / quotient / radicand shifter
  localparam int REM_W  = 16;  // partial remainder
  localparam int ROOT_W = 13;  // square root result
  localparam int ACC_W  = 14;  // window sum, up to 127 samples of 127
  localparam int AVG_W  = 15;  // q7.8 average

  // 10/sqrt(b/10) in q8 is sqrt(65536000 / b)
  localparam logic [SH_W-1:0] THR_DIVIDEND = 26'd65536000;

  localparam logic [4:0] DIV_STEPS_M1  = 5'd25;
  localparam logic [4:0] SQRT_STEPS_M1 = 5'd12;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WSTART,
    S_WALK,
    S_DLOAD,
    S_DIV,
    S_DSTORE,
    S_TH,
    S_TDIV,
    S_SQL,
    S_SQRT,
    S_DECIDE,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_CLR,
    UOP_ACC,
    UOP_LOAD_AVG,
    UOP_LOAD_DIVK,
    UOP_DIV_STEP,
    UOP_LOAD_SQRT,
    UOP_SQRT_STEP
  } uop_t;

  // command from the sequencer to the shared unit
  typedef struct packed {
    uop_t       op;
    logic [6:0] divisor;
  } unit_ctl_t;

endpackage

FILE: sv/hrft_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrft_ring
// sample ring memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module hrft_ring #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [6:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [6:0]    rdata
);

  logic [6:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/hrft_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrft_unit
// shared datapath: window accumulator and one compare-subtract step used
// for restoring division and digit-by-digit square root
// ----------------------------------------------------------------------------
module hrft_unit (
  input  logic                              clk,
  input  hrft_pkg::unit_ctl_t               ctl,
  input  logic [6:0]                        sample,
  output logic [hrft_pkg::SH_W-1:0]         quo,
  output logic [hrft_pkg::ROOT_W-1:0]       root
);

  logic [hrft_pkg::ACC_W-1:0] acc;
  logic [hrft_pkg::REM_W-1:0] rem;
  logic [hrft_pkg::SH_W-1:0]  sh;
  logic [hrft_pkg::REM_W-1:0] rem_s;
  logic [hrft_pkg::REM_W-1:0] trial;
  logic [hrft_pkg::REM_W:0]   diff;
  logic                       ge;

  // the one subtractor, fed per mode
  always_comb begin
    if (ctl.op == hrft_pkg::UOP_SQRT_STEP) begin
      rem_s = {rem[hrft_pkg::REM_W-3:0], sh[hrft_pkg::SH_W-1 -: 2]};
      trial = {1'b0, root, 2'b01};
    end else begin
      rem_s = {rem[hrft_pkg::REM_W-2:0], sh[hrft_pkg::SH_W-1]};
      trial = {9'd0, ctl.divisor};
    end
    diff = {1'b0, rem_s} - {1'b0, trial};
    ge   = !diff[hrft_pkg::REM_W];
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      hrft_pkg::UOP_CLR: begin
        acc <= '0;
      end
      hrft_pkg::UOP_ACC: begin
        acc <= acc + hrft_pkg::ACC_W'(sample);
      end
      hrft_pkg::UOP_LOAD_AVG: begin
        rem <= '0;
        sh  <= {4'd0, acc, 8'd0};
      end
      hrft_pkg::UOP_LOAD_DIVK: begin
        rem <= '0;
        sh  <= hrft_pkg::THR_DIVIDEND;
      end
      hrft_pkg::UOP_DIV_STEP: begin
        rem <= ge ? diff[hrft_pkg::REM_W-1:0] : rem_s;
        sh  <= {sh[hrft_pkg::SH_W-2:0], ge};
      end
      hrft_pkg::UOP_LOAD_SQRT: begin
        rem  <= '0;
        root <= '0;
      end
      hrft_pkg::UOP_SQRT_STEP: begin
        rem  <= ge ? diff[hrft_pkg::REM_W-1:0] : rem_s;
        root <= {root[hrft_pkg::ROOT_W-2:0], ge};
        sh   <= {sh[hrft_pkg::SH_W-3:0], 2'b00};
      end
      default: begin
      end
    endcase
  end

  assign quo = sh;

endmodule

FILE: sv/hrft_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrft_ctrl
// poll sequencer: sample gating, ring walk, averages and fan decision
// ----------------------------------------------------------------------------
module hrft_ctrl #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH),
  localparam int FW = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  hrft_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hrft_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hrft_pkg::out_item_t           out_data,
  output logic                          ring_we,
  output logic [AW-1:0]                 ring_waddr,
  output logic [6:0]                    ring_wdata,
  output logic [AW-1:0]                 ring_raddr,
  output hrft_pkg::unit_ctl_t           ctl,
  input  logic [hrft_pkg::SH_W-1:0]     quo,
  input  logic [hrft_pkg::ROOT_W-1:0]   root
);

  localparam int CW = (FW > 7) ? FW : 7;

  hrft_pkg::state_t state, state_next;

  logic [AW-1:0]             write_slot;
  logic [FW-1:0]             filled_count;
  logic [31:0]               last_sample_time;
  logic                      fan_state;
  logic [31:0]               switch_on_time;
  logic [hrft_pkg::AVG_W-1:0] release_level;
  logic [hrft_pkg::AVG_W-1:0] last_short_avg;
  logic [hrft_pkg::AVG_W-1:0] last_long_avg;
  logic                      taken;
  logic                      phase;
  logic                      pending;
  logic [6:0]                n_reg;
  logic [6:0]                cnt;
  logic [AW-1:0]             ptr;
  logic [4:0]                step;

  logic                      accept;
  logic                      taken_now;
  logic [31:0]               elapsed;
  logic [6:0]                win_sel;
  logic [CW-1:0]             win_x;
  logic [CW-1:0]             fill_x;
  logic [6:0]                n_sel;
  logic [AW-1:0]             ptr_dec;
  logic [AW-1:0]             slot_inc;
  logic                      issue;
  logic [6:0]                baseline;
  logic [15:0]               cap_q8;
  logic [15:0]               t_sum;
  logic [15:0]               thr;
  logic                      over_thr;
  logic [31:0]               on_time;
  logic                      off_now;

  always_comb begin
    accept    = in_valid && (state == hrft_pkg::S_IDLE);
    elapsed   = in_data.now_seconds - last_sample_time;
    taken_now = in_data.sensor_ok && (elapsed >= {16'd0, cfg.sample_period});
    win_sel   = phase ? cfg.long_window : cfg.short_window;
    win_x     = CW'(win_sel);
    fill_x    = CW'(filled_count);
    // fill never exceeds the ring depth, so this also caps at the depth
    n_sel     = (win_x < fill_x) ? win_sel : 7'(fill_x);
    ptr_dec   = (ptr == '0) ? AW'(DEPTH - 1) : ptr - 1'b1;
    slot_inc  = (write_slot == AW'(DEPTH - 1)) ? '0 : write_slot + 1'b1;
    issue     = (state == hrft_pkg::S_WALK) && (cnt != 7'd0);
    baseline  = last_long_avg[hrft_pkg::AVG_W-1:8];
    cap_q8    = {1'b0, cfg.trigger_cap, 8'd0};
    t_sum     = {1'b0, baseline, 8'd0} + 16'(root);
    if (baseline == 7'd0) begin
      thr = cap_q8;
    end else begin
      thr = (t_sum < cap_q8) ? t_sum : cap_q8;
    end
    over_thr  = {1'b0, last_short_avg} > thr;
    on_time   = last_sample_time - switch_on_time;
    off_now   = (last_short_avg < release_level) || (on_time > cfg.max_on_seconds);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hrft_pkg::S_IDLE: begin
        if (accept) begin
          state_next = taken_now ? hrft_pkg::S_WSTART : hrft_pkg::S_OUT;
        end
      end
      hrft_pkg::S_WSTART: begin
        if (n_sel != 7'd0) begin
          state_next = hrft_pkg::S_WALK;
        end else if (phase) begin
          state_next = hrft_pkg::S_TH;
        end
      end
      hrft_pkg::S_WALK: begin
        if (cnt == 7'd0 && !pending) begin
          state_next = hrft_pkg::S_DLOAD;
        end
      end
      hrft_pkg::S_DLOAD: state_next = hrft_pkg::S_DIV;
      hrft_pkg::S_DIV: begin
        if (step == 5'd0) begin
          state_next = hrft_pkg::S_DSTORE;
        end
      end
      hrft_pkg::S_DSTORE: begin
        state_next = phase ? hrft_pkg::S_TH : hrft_pkg::S_WSTART;
      end
      hrft_pkg::S_TH: begin
        if (fan_state || baseline == 7'd0) begin
          state_next = hrft_pkg::S_OUT;
        end else begin
          state_next = hrft_pkg::S_TDIV;
        end
      end
      hrft_pkg::S_TDIV: begin
        if (step == 5'd0) begin
          state_next = hrft_pkg::S_SQL;
        end
      end
      hrft_pkg::S_SQL: state_next = hrft_pkg::S_SQRT;
      hrft_pkg::S_SQRT: begin
        if (step == 5'd0) begin
          state_next = hrft_pkg::S_DECIDE;
        end
      end
      hrft_pkg::S_DECIDE: state_next = hrft_pkg::S_OUT;
      hrft_pkg::S_OUT: begin
        if (out_ready) begin
          state_next = hrft_pkg::S_IDLE;
        end
      end
      default: state_next = hrft_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = (state == hrft_pkg::S_IDLE);
    out_valid   = (state == hrft_pkg::S_OUT);
    ring_we     = accept && taken_now;
    ring_waddr  = write_slot;
    ring_wdata  = in_data.humidity;
    ring_raddr  = ptr_dec;
    ctl.op      = hrft_pkg::UOP_NOP;
    ctl.divisor = n_reg;
    case (state)
      hrft_pkg::S_WSTART: ctl.op = hrft_pkg::UOP_CLR;
      hrft_pkg::S_WALK: begin
        if (pending) begin
          ctl.op = hrft_pkg::UOP_ACC;
        end
      end
      hrft_pkg::S_DLOAD: ctl.op = hrft_pkg::UOP_LOAD_AVG;
      hrft_pkg::S_DIV:   ctl.op = hrft_pkg::UOP_DIV_STEP;
      hrft_pkg::S_TH:    ctl.op = hrft_pkg::UOP_LOAD_DIVK;
      hrft_pkg::S_TDIV: begin
        ctl.op      = hrft_pkg::UOP_DIV_STEP;
        ctl.divisor = baseline;
      end
      hrft_pkg::S_SQL:   ctl.op = hrft_pkg::UOP_LOAD_SQRT;
      hrft_pkg::S_SQRT:  ctl.op = hrft_pkg::UOP_SQRT_STEP;
      default: begin
      end
    endcase
  end

  assign out_data.fan_on        = fan_state;
  assign out_data.sample_taken  = taken;
  assign out_data.short_average = last_short_avg;
  assign out_data.long_average  = last_long_avg;

  // control and poll state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= hrft_pkg::S_IDLE;
      write_slot       <= '0;
      filled_count     <= '0;
      last_sample_time <= '0;
      fan_state        <= 1'b0;
      switch_on_time   <= '0;
      release_level    <= '0;
      last_short_avg   <= '0;
      last_long_avg    <= '0;
      taken            <= 1'b0;
      phase            <= 1'b0;
      pending          <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= issue;
      if (accept) begin
        taken <= taken_now;
        phase <= 1'b0;
        if (taken_now) begin
          last_sample_time <= in_data.now_seconds;
          write_slot       <= slot_inc;
          if (filled_count < FW'(DEPTH)) begin
            filled_count <= filled_count + 1'b1;
          end
        end
      end
      if (state == hrft_pkg::S_WSTART && n_sel == 7'd0) begin
        phase <= 1'b1;
        if (phase) begin
          last_long_avg <= '0;
        end else begin
          last_short_avg <= '0;
        end
      end
      if (state == hrft_pkg::S_DSTORE) begin
        phase <= 1'b1;
        if (phase) begin
          last_long_avg <= quo[hrft_pkg::AVG_W-1:0];
        end else begin
          last_short_avg <= quo[hrft_pkg::AVG_W-1:0];
        end
      end
      if (state == hrft_pkg::S_TH && fan_state && off_now) begin
        fan_state <= 1'b0;
      end
      if ((state == hrft_pkg::S_TH && !fan_state && baseline == 7'd0) ||
          state == hrft_pkg::S_DECIDE) begin
        if (over_thr) begin
          fan_state      <= 1'b1;
          release_level  <= last_short_avg;
          switch_on_time <= last_sample_time;
        end
      end
    end
  end

  // walk and step counters, loaded before every use
  always_ff @(posedge clk) begin
    if (state == hrft_pkg::S_WSTART) begin
      n_reg <= n_sel;
      cnt   <= n_sel;
      ptr   <= write_slot;
    end
    if (issue) begin
      cnt <= cnt - 1'b1;
      ptr <= ptr_dec;
    end
    if (state == hrft_pkg::S_DLOAD || state == hrft_pkg::S_TH) begin
      step <= hrft_pkg::DIV_STEPS_M1;
    end else if (state == hrft_pkg::S_SQL) begin
      step <= hrft_pkg::SQRT_STEPS_M1;
    end else if (state == hrft_pkg::S_DIV || state == hrft_pkg::S_TDIV ||
                 state == hrft_pkg::S_SQRT) begin
      step <= step - 1'b1;
    end
  end

endmodule

FILE: sv/humidity_rise_fan_trigger_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_rise_fan_trigger_core
// bathroom fan trigger from a rise of short vs long humidity average
// ----------------------------------------------------------------------------
// a poll that takes no sample goes straight to its result; one that does
//   walks and divides each window in turn, an empty window skipping both,
//   then runs the threshold divide and square root when the fan is off and
//   the baseline is nonzero
// throughput: one poll at a time, set by the ring walk and serial divide / root
// reset: synchronous, active high; ring contents undefined, never read unwritten
module humidity_rise_fan_trigger_core #(
  parameter int RING_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hrft_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hrft_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int AW = $clog2(RING_DEPTH);

  hrft_pkg::cfg_t cfg;

  logic                          ring_we;
  logic [AW-1:0]                 ring_waddr;
  logic [6:0]                    ring_wdata;
  logic [AW-1:0]                 ring_raddr;
  logic [6:0]                    ring_rdata;
  hrft_pkg::unit_ctl_t           ctl;
  logic [hrft_pkg::SH_W-1:0]     quo;
  logic [hrft_pkg::ROOT_W-1:0]   root;

  // configuration regs; user writes only while no poll in flight, not enforced
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_period  <= hrft_pkg::RST_SAMPLE_PERIOD;
      cfg.short_window   <= hrft_pkg::RST_SHORT_WINDOW;
      cfg.long_window    <= hrft_pkg::RST_LONG_WINDOW;
      cfg.max_on_seconds <= hrft_pkg::RST_MAX_ON_SECONDS;
      cfg.trigger_cap    <= hrft_pkg::RST_TRIGGER_CAP;
    end else if (cfg_we) begin
      case (cfg_index)
        hrft_pkg::REG_SAMPLE_PERIOD:  cfg.sample_period  <= cfg_data[15:0];
        hrft_pkg::REG_SHORT_WINDOW:   cfg.short_window   <= cfg_data[6:0];
        hrft_pkg::REG_LONG_WINDOW:    cfg.long_window    <= cfg_data[6:0];
        hrft_pkg::REG_MAX_ON_SECONDS: cfg.max_on_seconds <= cfg_data;
        hrft_pkg::REG_TRIGGER_CAP:    cfg.trigger_cap    <= cfg_data[6:0];
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  // sample ring, newest entry sits just below write_slot
  hrft_ring #(
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // shared accumulate / divide / square root datapath
  hrft_unit u_unit (
    .clk    (clk),
    .ctl    (ctl),
    .sample (ring_rdata),
    .quo    (quo),
    .root   (root)
  );

  // sequencer: gates the poll, walks both windows, decides the fan
  hrft_ctrl #(
    .DEPTH (RING_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .ring_we    (ring_we),
    .ring_waddr (ring_waddr),
    .ring_wdata (ring_wdata),
    .ring_raddr (ring_raddr),
    .ctl        (ctl),
    .quo        (quo),
    .root       (root)
  );

  // a result waiting and a new poll being taken never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready))
    else $error("result pending while accepting a poll");

  // after an input transfer the block is busy
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready again right after an input transfer");

  // the ring is only written on an input transfer
  a_ring_write: assert property (@(posedge clk) disable iff (rst)
    ring_we |-> (in_valid && in_ready))
    else $error("ring written outside an input transfer");

  // after a result transfer the block is idle again
  a_idle_after_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> in_ready)
    else $error("not idle after a result transfer");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the humidity rise fan trigger core
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RING        = 64;
  localparam int IDLE_PCT    = 36;    // percent of cycles a side sits idle
  localparam int STALL_LIMIT = 5000;  // cycles without any transfer or register write
  localparam int SETTLE      = 300;   // worst poll latency, rounded up

  // 10/sqrt(b/10) scaled to q8 is sqrt(65536000 / b)
  localparam int unsigned RISE_NUM = 32'd65536000;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  hrft_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  hrft_pkg::out_item_t out_data;
  logic                cfg_we    = 1'b0;
  logic [2:0]          cfg_index = '0;
  logic [31:0]         cfg_data  = '0;

  // both sides run without idling while this is set
  bit          full_rate = 1'b0;
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  logic [31:0] wall = '0;          // stimulus time base, seconds

  // results still owed by the block, oldest first
  hrft_pkg::out_item_t fan_expect [$];

  // predictor state
  logic [6:0]     hist [RING];
  logic [5:0]     head;
  logic [6:0]     fill;
  logic [31:0]    last_take;
  logic           fan;
  logic [31:0]    on_since;
  logic [14:0]    release_q8;
  logic [14:0]    short_q8;
  logic [14:0]    long_q8;
  hrft_pkg::cfg_t regs;

  always #5 clk = ~clk;

  humidity_rise_fan_trigger_core #(
    .RING_DEPTH(RING)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // q8 mean of the newest entries, walking back from the write slot
  function automatic logic [14:0] window_mean(input logic [6:0] span);
    int unsigned n;
    int unsigned total;
    logic [5:0]  pos;
    n = span;
    if (n > fill) n = fill;
    if (n > RING) n = RING;
    if (n == 0) return '0;
    total = 0;
    pos = head;
    for (int k = 0; k < n; k++) begin
      pos = pos - 6'd1;
      total += hist[pos];
    end
    return 15'((total * 256) / n);
  endfunction

  function automatic hrft_pkg::out_item_t fan_model_step(input hrft_pkg::in_item_t p);
    hrft_pkg::out_item_t res;
    logic [31:0] age;
    logic [31:0] on_for;
    int unsigned lim;
    int unsigned trip;
    int unsigned quot;
    int unsigned root;
    int unsigned cand;
    age = p.now_seconds - last_take;
    res.sample_taken = p.sensor_ok && (age >= {16'd0, regs.sample_period});
    if (res.sample_taken) begin
      last_take  = p.now_seconds;
      hist[head] = p.humidity;
      head       = head + 6'd1;
      if (fill < RING) fill = fill + 7'd1;
      short_q8 = window_mean(regs.short_window);
      long_q8  = window_mean(regs.long_window);
      if (fan) begin
        // either a fall below the switch-on level or a long run ends it
        on_for = p.now_seconds - on_since;
        if (short_q8 < release_q8 || on_for > regs.max_on_seconds) fan = 1'b0;
      end else begin
        lim = regs.trigger_cap * 256;
        if (long_q8[14:8] == 0) begin
          trip = lim;
        end else begin
          // floor square root, one result bit at a time
          quot = RISE_NUM / long_q8[14:8];
          root = 0;
          for (int b = 12; b >= 0; b--) begin
            cand = root | (1 << b);
            if (cand * cand <= quot) root = cand;
          end
          trip = long_q8[14:8] * 256 + root;
          if (trip > lim) trip = lim;
        end
        if (short_q8 > trip) begin
          fan        = 1'b1;
          release_q8 = short_q8;
          on_since   = p.now_seconds;
        end
      end
    end
    res.fan_on        = fan;
    res.short_average = short_q8;
    res.long_average  = long_q8;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // result checking and watchdog
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    hrft_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (fan_expect.size() == 0) begin
        flag_mismatch("result with no poll waiting", out_data, 0);
      end else begin
        want = fan_expect.pop_front();
        if (out_data.fan_on !== want.fan_on)
          flag_mismatch("fan_on", out_data.fan_on, want.fan_on);
        if (out_data.sample_taken !== want.sample_taken)
          flag_mismatch("sample_taken", out_data.sample_taken, want.sample_taken);
        if (out_data.short_average !== want.short_average)
          flag_mismatch("short_average", out_data.short_average, want.short_average);
        if (out_data.long_average !== want.long_average)
          flag_mismatch("long_average", out_data.long_average, want.long_average);
      end
    end
  end

  // any transfer or register write counts as progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= full_rate || ($urandom_range(99) >= IDLE_PCT);
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // valid is left high after the transfer; a drain, or a gap in the next call, drops it
  task automatic send_poll(input logic [31:0] now, input logic ok,
                           input logic [6:0] hum);
    int                 gap;
    hrft_pkg::in_item_t p;
    gap = 0;
    if (!full_rate) begin
      // now and then a long pause so gaps land in every phase of the block
      if ($urandom_range(99) < 5) gap = $urandom_range(300, 1);
      else while ($urandom_range(99) < IDLE_PCT) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    p.now_seconds = now;
    p.sensor_ok   = ok;
    p.humidity    = hum;
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    fan_expect.push_back(fan_model_step(p));
  endtask

  // every poll has a result, so an empty queue means the block is idle
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (fan_expect.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // writes all five registers, with junk above each register's width
  task automatic load_settings(input hrft_pkg::cfg_t s);
    logic [31:0] junk;
    wait_results_drained();
    junk = $urandom;
    cfg_we    <= 1'b1;
    cfg_index <= hrft_pkg::REG_SAMPLE_PERIOD;
    cfg_data  <= {junk[31:16], s.sample_period};
    @(posedge clk);
    cfg_index <= hrft_pkg::REG_SHORT_WINDOW;
    cfg_data  <= {junk[31:7], s.short_window};
    @(posedge clk);
    cfg_index <= hrft_pkg::REG_LONG_WINDOW;
    cfg_data  <= {junk[24:0], s.long_window};
    @(posedge clk);
    cfg_index <= hrft_pkg::REG_MAX_ON_SECONDS;
    cfg_data  <= s.max_on_seconds;
    @(posedge clk);
    cfg_index <= hrft_pkg::REG_TRIGGER_CAP;
    cfg_data  <= {junk[30:6], s.trigger_cap};
    @(posedge clk);
    // an index past the last register must change nothing
    cfg_index <= 3'(hrft_pkg::REG_TRIGGER_CAP + $urandom_range(3, 1));
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    regs = s;
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  // shower episodes: flat base, quick rise, slow decay, with noise,
  // sensor errors, early polls and clock jumps mixed in
  task automatic shower_run(input int polls);
    int          k;
    int          span;
    int          base;
    int          peak;
    int          hum;
    int          pct;
    logic        ok;
    logic [31:0] step;
    k = 0;
    span = 0;
    base = 40;
    peak = 80;
    repeat (polls) begin
      if (k >= span) begin
        base = $urandom_range(70, 10);
        peak = base + $urandom_range(45, 4);
        span = $urandom_range(40, 16);
        k = 0;
      end
      if (k < span / 3)
        hum = base;
      else if (k < span / 3 + 3)
        hum = base + (peak - base) * (k - span / 3 + 1) / 3;
      else
        hum = peak - (peak - base) * (k - span / 3 - 3) / (span - span / 3 - 3);
      hum += int'($urandom_range(4)) - 2;
      if (hum < 0) hum = 0;
      if (hum > 127) hum = 127;
      ok  = 1'b1;
      pct = $urandom_range(99);
      if (pct < 6) ok = 1'b0;
      else if (pct < 14) hum = $urandom_range(127);
      step = regs.sample_period + $urandom_range(regs.sample_period / 4 + 2);
      pct  = $urandom_range(99);
      if (pct < 10 && regs.sample_period != 0)
        step = $urandom_range(regs.sample_period - 1);
      else if (pct < 12)
        step = $urandom;
      wall = wall + step;
      send_poll(wall, ok, 7'(hum));
      k++;
    end
  endtask

  // reset settings: early polls, sensor error, humidity extremes
  task automatic test_poll_timing();
    send_poll(32'd0,   1'b1, 7'd50);   // too early at time zero
    send_poll(32'd59,  1'b1, 7'd50);   // one second short
    send_poll(32'd60,  1'b1, 7'd0);
    send_poll(32'd61,  1'b1, 7'd127);  // too early
    send_poll(32'd200, 1'b0, 7'd127);  // sensor error holds everything
    send_poll(32'd200, 1'b1, 7'd127);
    send_poll(32'd260, 1'b1, 7'd100);
    wall = 32'd260;
  endtask

  task automatic test_register_extremes();
    // one-second period, long window beyond the ring, zero cap, no time limit
    load_settings('{16'd1, 7'd1, 7'd127, 32'hFFFF_FFFF, 7'd0});
    send_poll(32'd261, 1'b1, 7'd5);
    send_poll(32'd262, 1'b1, 7'd3);    // below the switch-on level
    send_poll(32'd263, 1'b1, 7'd3);
    send_poll(32'd263, 1'b1, 7'd90);   // same second, too early
    // zero period, long window of one, no on time allowed
    load_settings('{16'd0, 7'd2, 7'd1, 32'd0, 7'd50});
    send_poll(32'd300, 1'b1, 7'd127);
    send_poll(32'd300, 1'b1, 7'd0);    // zero baseline, threshold is the cap
    send_poll(32'd301, 1'b1, 7'd0);    // on time over the limit
    send_poll(32'd301, 1'b1, 7'd127);
    // zero short window, clock wraps
    load_settings('{16'd60, 7'd0, 7'd64, 32'd14400, 7'd85});
    send_poll(32'hFFFF_FFF0, 1'b1, 7'd100);
    send_poll(32'h0000_002C, 1'b1, 7'd64);  // exactly one period across the wrap
    send_poll(32'h0000_0030, 1'b1, 7'd1);   // too early after the wrap
    wall = 32'h0000_0030;
  endtask

  task automatic test_showers();
    hrft_pkg::cfg_t plan [6];
    plan[0] = '{16'd60,    7'd4,   7'd64, 32'd14400,       7'd100};
    plan[1] = '{16'd1,     7'd1,   7'd16, 32'd300,         7'd85};
    plan[2] = '{16'd65535, 7'd64,  7'd64, 32'd0,           7'd127};
    plan[3] = '{16'd30,    7'd2,   7'd32, 32'hFFFF_FFFF,   7'd0};
    plan[4] = '{16'd10,    7'd127, 7'd1,  32'd600,         7'd60};
    plan[5] = '{16'd5,     7'd3,   7'd24, 32'd120,         7'd90};
    for (int i = 0; i < 6; i++) begin
      load_settings(plan[i]);
      shower_run(42);
      // hold polls until every result is back, then carry on
      if (i == 0) wait_results_drained();
      shower_run(42);
    end
  endtask

  // a long stretch where neither side idles
  task automatic test_back_to_back();
    load_settings('{16'd20, 7'd4, 7'd40, 32'd2000, 7'd85});
    full_rate = 1'b1;
    shower_run(80);
    full_rate = 1'b0;
  endtask

  initial begin
    head       = '0;
    fill       = '0;
    last_take  = '0;
    fan        = 1'b0;
    on_since   = '0;
    release_q8 = '0;
    short_q8   = '0;
    long_q8    = '0;
    regs = '{hrft_pkg::RST_SAMPLE_PERIOD, hrft_pkg::RST_SHORT_WINDOW,
             hrft_pkg::RST_LONG_WINDOW, hrft_pkg::RST_MAX_ON_SECONDS,
             hrft_pkg::RST_TRIGGER_CAP};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_poll_timing();
    test_register_extremes();
    test_showers();
    test_back_to_back();
    wait_results_drained();
    // anything the block sends now is a stray result
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
